### design/mcrb_pkg.sv
// Shared types and constants for the multi-channel receive ring buffer.
// Used by the controller, the datapath and the top level. No dependencies.
package mcrb_pkg;

  // Item kinds carried in the low bits of the input tuser.
  typedef enum logic [1:0] {
    OP_RX_BYTE     = 2'd0,
    OP_READ_BURST  = 2'd1,
    OP_QUERY_LEVEL = 2'd2,
    OP_READ_CLEAR  = 2'd3
  } mcrb_op_e;

  localparam int unsigned ErrW      = 16;
  localparam logic [ErrW-1:0] ErrMax = 16'hFFFF;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned FillW     = 6;
  localparam int unsigned ReqW      = 5;
  localparam int unsigned ChanFldW  = 2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;      // latch the accepted input item
    logic do_write;     // apply a received byte (store it, count a line error, or both when the ring is full)
    logic load_single;  // load the one result of a non-burst or empty item
    logic start_burst;  // load the burst length
    logic rd_issue;     // read one byte and advance the read position
    logic load_burst;   // load the byte read into the output register
  } mcrb_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    mcrb_op_e op;
    logic     ch_valid;
    logic     burst_empty;
    logic     out_free;
    logic     count_zero;
  } mcrb_sts_t;

endpackage

### design/mcrb_ctrl.sv
// Controller state machine of the multi-channel receive ring buffer.
// Depends on mcrb_pkg for the command, status and item kind types.
module mcrb_ctrl
  import mcrb_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  mcrb_sts_t sts_i,
  output mcrb_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_READ,
    S_WAIT
  } state_e;

  state_e state_q;
  state_e state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts_i.op == OP_RX_BYTE) begin
          cmd_o.do_write = sts_i.ch_valid;
          state_d        = S_IDLE;
        end else if (sts_i.op == OP_READ_BURST && sts_i.ch_valid && !sts_i.burst_empty) begin
          cmd_o.start_burst = 1'b1;
          state_d           = S_READ;
        end else if (sts_i.out_free) begin
          cmd_o.load_single = 1'b1;
          state_d           = S_IDLE;
        end
      end
      S_READ: begin
        cmd_o.rd_issue = 1'b1;
        state_d        = S_WAIT;
      end
      S_WAIT: begin
        if (sts_i.out_free) begin
          cmd_o.load_burst = 1'b1;
          state_d          = sts_i.count_zero ? S_IDLE : S_READ;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### design/mcrb_dpath.sv
// Datapath of the multi-channel receive ring buffer: item register, per-channel
// positions and error counters, the byte store and the output register.
// Depends on mcrb_pkg.
module mcrb_dpath
  import mcrb_pkg::*;
#(
  parameter int unsigned CHANNELS  = 4,
  parameter int unsigned DEPTH     = 64,
  parameter int unsigned MAX_BURST = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  mcrb_cmd_t       cmd_i,
  output mcrb_sts_t       sts_o,
  input  logic [15:0]     in_tdata_i,
  input  logic [3:0]      in_tuser_i,
  input  logic            out_ready_i,
  output logic            out_valid_o,
  output logic [31:0]     out_tdata_o,
  output logic            out_tlast_o
);

  localparam int unsigned PW   = $clog2(DEPTH);
  localparam int unsigned LW   = PW + 1;
  localparam int unsigned CW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned AW   = $clog2(CHANNELS * DEPTH);
  localparam int unsigned MEMN = CHANNELS * DEPTH;
  localparam int unsigned NW   = $clog2(MAX_BURST + 1);
  localparam int unsigned CMPW = (PW > 7) ? PW : 7;

  // Captured item.
  mcrb_op_e                op_q;
  logic [ChanFldW-1:0]     ch_q;
  logic [ByteW-1:0]        byte_q;
  logic                    lerr_q;
  logic [ReqW-1:0]         req_q;

  // Per-channel state.
  logic [PW-1:0]           wpos_q [CHANNELS];
  logic [PW-1:0]           rpos_q [CHANNELS];
  logic [ErrW-1:0]         err_q  [CHANNELS];

  logic [ByteW-1:0]        mem [MEMN];
  logic [ByteW-1:0]        rd_data_q;
  logic [NW-1:0]           count_q;

  logic                    out_valid_q;
  logic [ByteW-1:0]        o_data_q;
  logic                    o_dv_q;
  logic [FillW-1:0]        o_fill_q;
  logic [ErrW-1:0]         o_err_q;
  logic                    o_last_q;

  logic [CW-1:0]           ch_idx;
  logic                    ch_valid;
  logic [PW-1:0]           w_cur;
  logic [PW-1:0]           r_cur;
  logic [PW-1:0]           w_next;
  logic [PW-1:0]           r_next;
  logic [PW-1:0]           lvl;
  logic [LW-1:0]           lvl_wrap;
  logic [6:0]              req_clip;
  logic [CMPW-1:0]         n_full;
  logic [AW-1:0]           wr_addr;
  logic [AW-1:0]           rd_addr;
  logic                    store;
  logic                    bump;
  logic                    clear_err;
  logic [ErrW-1:0]         err_cur;
  logic                    out_free;

  assign ch_idx   = CW'(ch_q);
  assign ch_valid = (32'(ch_q) < CHANNELS);
  assign w_cur    = wpos_q[ch_idx];
  assign r_cur    = rpos_q[ch_idx];
  assign err_cur  = err_q[ch_idx];

  assign w_next = (32'(w_cur) == DEPTH - 1) ? '0 : w_cur + PW'(1);
  assign r_next = (32'(r_cur) == DEPTH - 1) ? '0 : r_cur + PW'(1);

  // Fill level, wrapping at the full depth.
  assign lvl_wrap = {1'b0, w_cur} + LW'(DEPTH) - {1'b0, r_cur};
  assign lvl      = (w_cur >= r_cur) ? (w_cur - r_cur) : PW'(lvl_wrap);

  // Burst length: the request, clipped to the burst limit and the level.
  assign req_clip = (7'(req_q) < 7'(MAX_BURST)) ? 7'(req_q) : 7'(MAX_BURST);
  assign n_full   = (CMPW'(req_clip) < CMPW'(lvl)) ? CMPW'(req_clip) : CMPW'(lvl);

  assign wr_addr = AW'(ch_idx) * AW'(DEPTH) + AW'(w_cur);
  assign rd_addr = AW'(ch_idx) * AW'(DEPTH) + AW'(r_cur);

  assign store     = cmd_i.do_write && !lerr_q;
  assign bump      = cmd_i.do_write && (lerr_q || (w_next == r_cur));
  assign clear_err = cmd_i.load_single && ch_valid && (op_q == OP_READ_CLEAR);
  assign out_free  = !out_valid_q || out_ready_i;

  assign sts_o.op          = op_q;
  assign sts_o.ch_valid    = ch_valid;
  assign sts_o.burst_empty = (n_full == '0);
  assign sts_o.out_free    = out_free;
  assign sts_o.count_zero  = (count_q == '0);

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q   <= mcrb_op_e'(in_tuser_i[1:0]);
      ch_q   <= in_tuser_i[3:2];
      byte_q <= in_tdata_i[7:0];
      lerr_q <= in_tdata_i[8];
      req_q  <= in_tdata_i[13:9];
    end
    if (cmd_i.start_burst) begin
      count_q <= NW'(n_full);
    end else if (cmd_i.rd_issue) begin
      count_q <= count_q - NW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (store) begin
      mem[wr_addr] <= byte_q;
    end
    if (cmd_i.rd_issue) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        wpos_q[i] <= '0;
        rpos_q[i] <= '0;
        err_q[i]  <= '0;
      end
    end else begin
      if (store) begin
        wpos_q[ch_idx] <= w_next;
      end
      if (cmd_i.rd_issue) begin
        rpos_q[ch_idx] <= r_next;
      end
      if (clear_err) begin
        err_q[ch_idx] <= '0;
      end else if (bump && err_cur != ErrMax) begin
        err_q[ch_idx] <= err_cur + ErrW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_single || cmd_i.load_burst) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_single) begin
      o_data_q <= '0;
      o_dv_q   <= 1'b0;
      o_fill_q <= ch_valid ? FillW'(lvl) : '0;
      o_err_q  <= clear_err ? err_cur : '0;
      o_last_q <= 1'b1;
    end else if (cmd_i.load_burst) begin
      o_data_q <= rd_data_q;
      o_dv_q   <= 1'b1;
      o_fill_q <= FillW'(lvl);
      o_err_q  <= '0;
      o_last_q <= (count_q == '0);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_tdata_o = {1'b0, o_err_q, o_fill_q, o_dv_q, o_data_q};
  assign out_tlast_o = o_last_q;

endmodule

### design/multi_channel_rx_ring_buffer_core.sv
// A received byte is stored in the cycle after acceptance; a single-result item
// (level query, error read, empty burst) loads its result into the output register
// once that register is free. Items are taken one at a time; a burst reads each byte
// in a read state and a wait state, set by the registered read port of the shared store.
// Reset: asynchronous, active low; clears all positions and error counters at once.
// The byte store is not cleared and needs no sweep, so items are taken right after reset.
module multi_channel_rx_ring_buffer_core
  import mcrb_pkg::*;
#(
  parameter int unsigned CHANNELS  = 4,
  parameter int unsigned DEPTH     = 64,
  parameter int unsigned MAX_BURST = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // Input tdata, from bit 0: rx_byte[7:0], line_error[8], read_count[13:9], zero pad.
  input  logic [15:0] s_axis_tdata,
  // Input tuser, from bit 0: op[1:0], channel[3:2].
  input  logic [3:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // Output tdata, from bit 0: read_data[7:0], data_valid[8], fill_level[14:9],
  // error_count[30:15], zero pad[31].
  output logic [31:0] m_axis_tdata,
  output logic        m_axis_tlast
);

  // The controller sequences each item; the datapath owns every piece of storage.
  // The two talk only through the command and status structs.
  mcrb_cmd_t cmd;
  mcrb_sts_t sts;

  mcrb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // The output register in the datapath lets the controller return to idle and
  // take the next item while the last result still waits on the master side.
  mcrb_dpath #(
    .CHANNELS  (CHANNELS),
    .DEPTH     (DEPTH),
    .MAX_BURST (MAX_BURST)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_tdata_i  (s_axis_tdata),
    .in_tuser_i  (s_axis_tuser),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_tdata_o (m_axis_tdata),
    .out_tlast_o (m_axis_tlast)
  );

endmodule

### design/mcrb_chk.sv
// Port-level checker for the multi-channel receive ring buffer, bound to the top level.
// Depends only on the top level's ports.
module mcrb_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  // A result that is held back keeps its contents.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output item changed while stalled");

  // Items are worked one at a time: no second item right after an accepted one.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while previous item in flight");

  // A result without a byte carries a zero byte.
  a_no_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[8] |-> m_axis_tdata[7:0] == 8'h00)
    else $error("nonzero data on a result without a byte");

  // A byte result never reports an error count.
  a_byte_no_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[8] |-> m_axis_tdata[30:15] == 16'h0000)
    else $error("error count on a byte result");

endmodule

bind multi_channel_rx_ring_buffer_core mcrb_chk u_mcrb_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
